// ===== rtl/boolean_infix_to_postfix_core_macros.svh =====
// Assertion macros for the infix-to-postfix converter checker.
// Needs clk and rst_n in scope where used.
`ifndef BOOLEAN_INFIX_TO_POSTFIX_CORE_MACROS_SVH
`define BOOLEAN_INFIX_TO_POSTFIX_CORE_MACROS_SVH

// Checked only outside reset
`define BI2P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define BI2P_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bi2p_pkg.sv =====
// Shared types, character codes and decode functions for the converter.
// No dependencies.
package bi2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_EQU    = 8'h3D; // '='
    localparam logic [7:0] CH_IMP    = 8'h3E; // '>'
    localparam logic [7:0] CH_OR_LC  = 8'h76; // 'v'
    localparam logic [7:0] CH_OR_UC  = 8'h56; // 'V'
    localparam logic [7:0] CH_AND    = 8'h26; // '&'
    localparam logic [7:0] CH_XOR    = 8'h5E; // '^'
    localparam logic [7:0] CH_NOT    = 8'h7E; // '~'
    localparam logic [7:0] CH_NEG    = 8'h2D; // '-'
    localparam logic [7:0] CH_LPAREN = 8'h28; // '('
    localparam logic [7:0] CH_RPAREN = 8'h29; // ')'

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TEST
    } state_t;

    typedef enum logic [2:0] {
        KIND_SKIP,
        KIND_END,
        KIND_LETTER,
        KIND_OP,
        KIND_LPAREN,
        KIND_RPAREN
    } kind_t;

    // Precedence; '(' and anything else rank 0
    function automatic logic [2:0] rank_of(input logic [7:0] c);
        logic [2:0] r;
        begin
            case (c)
                CH_EQU:             r = 3'd1;
                CH_IMP:             r = 3'd2;
                CH_OR_LC, CH_OR_UC: r = 3'd3;
                CH_AND, CH_XOR:     r = 3'd4;
                CH_NOT, CH_NEG:     r = 3'd5;
                default:            r = 3'd0;
            endcase
            return r;
        end
    endfunction

    function automatic kind_t kind_of(input logic [7:0] c);
        kind_t k;
        begin
            if (c == CH_END)
                k = KIND_END;
            else if (rank_of(c) != 3'd0)
                k = KIND_OP;
            else if (c == CH_LPAREN)
                k = KIND_LPAREN;
            else if (c == CH_RPAREN)
                k = KIND_RPAREN;
            else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})
                k = KIND_LETTER;
            else
                k = KIND_SKIP;
            return k;
        end
    endfunction

endpackage

// ===== rtl/boolean_infix_to_postfix_core.sv =====
// Boolean infix-to-postfix converter (shunting-yard) top level.
// Uses bi2p_pkg for character codes, decode functions and state types.
//
// Input channel: one expression character per beat on ch (in_valid/in_ready).
// A zero byte ends the expression. Output channel: one postfix beat on
// sym/last/error (out_valid/out_ready). Operands and operators come out in
// postfix order; the end flushes the operator stack and then sends a zero
// beat with last set. A ')' without an open '(' on the stack, or a push onto
// a full stack, drops the character and sends one beat with error set.
// Spaces and unknown bytes are swallowed without a beat.
//
// Sequencing: in_ready is high only while the sequencer is idle. An
// accepted character keeps the sequencer busy through a load-top step and
// a test step, and through both again for every stack entry it pops and
// emits; the stack memory's registered read port is why each test needs
// its load step. The sequencer returns to idle before it takes another
// character, so none is accepted while the last is still in work. The
// first result beat enters the output register in the test step. Ignored
// bytes leave in_ready high. Operators are pushed and popped once each.
//
// A result waits in the output register; a stall on out_ready holds the
// sequencer in its test step until the beat is taken, and the next character
// may be accepted while the final beat of the previous one still waits.
// Reset empties the stack (count cleared, no memory sweep) and drops any
// pending output beat.
module boolean_infix_to_postfix_core #(
    parameter int STACK_DEPTH = bi2p_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] sym,
    output logic       last,
    output logic       error
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Sequencer and stack pointers
    bi2p_pkg::state_t state_reg, state_next;
    bi2p_pkg::kind_t  kind_reg, kind_next;
    logic [7:0]       ch_reg, ch_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    paren_reg, paren_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       sym_reg, sym_next;
    logic             last_reg, last_next;
    logic             error_reg, error_next;

    // Operator stack, registered read of the top entry
    logic [7:0]       stack_mem [STACK_DEPTH];
    logic [7:0]       top_reg;
    logic [CW-1:0]    count_dec;
    logic [AW-1:0]    rd_addr;

    // Decisions taken in the test step
    logic             want_emit;
    logic [7:0]       emit_sym;
    logic             emit_last;
    logic             emit_err;
    logic             do_pop;
    logic             do_push;
    logic             done;
    logic             slot_free;
    logic             go;
    logic             stack_empty;
    logic             stack_full;
    logic             top_is_lparen;

    assign count_dec     = count_reg - CW'(1);
    assign rd_addr       = count_dec[AW-1:0];
    assign stack_empty   = (count_reg == '0);
    assign stack_full    = (count_reg == CW'(STACK_DEPTH));
    assign top_is_lparen = (top_reg == bi2p_pkg::CH_LPAREN);
    assign slot_free     = !out_valid_reg || out_ready;
    assign go            = (state_reg == bi2p_pkg::ST_TEST) && (!want_emit || slot_free);

    always_ff @(posedge clk)
    begin
        if (go && do_push)
        begin
            stack_mem[count_reg[AW-1:0]] <= ch_reg;
        end
        top_reg <= stack_mem[rd_addr];
    end

    // What the test step would do with the current top
    always_comb
    begin
        want_emit = 1'b0;
        emit_sym  = 8'h00;
        emit_last = 1'b0;
        emit_err  = 1'b0;
        do_pop    = 1'b0;
        do_push   = 1'b0;
        done      = 1'b1;
        case (kind_reg)
            bi2p_pkg::KIND_END:
            begin
                want_emit = 1'b1;
                if (!stack_empty)
                begin
                    emit_sym = top_reg;
                    do_pop   = 1'b1;
                    done     = 1'b0;
                end
                else
                begin
                    emit_last = 1'b1;
                end
            end
            bi2p_pkg::KIND_LETTER:
            begin
                want_emit = 1'b1;
                emit_sym  = ch_reg;
            end
            bi2p_pkg::KIND_OP:
            begin
                if (!stack_empty && (bi2p_pkg::rank_of(top_reg) >= bi2p_pkg::rank_of(ch_reg)))
                begin
                    want_emit = 1'b1;
                    emit_sym  = top_reg;
                    do_pop    = 1'b1;
                    done      = 1'b0;
                end
                else if (!stack_full)
                begin
                    do_push = 1'b1;
                end
                else
                begin
                    want_emit = 1'b1;
                    emit_err  = 1'b1;
                end
            end
            bi2p_pkg::KIND_LPAREN:
            begin
                if (!stack_full)
                begin
                    do_push = 1'b1;
                end
                else
                begin
                    want_emit = 1'b1;
                    emit_err  = 1'b1;
                end
            end
            bi2p_pkg::KIND_RPAREN:
            begin
                if (paren_reg == '0)
                begin
                    want_emit = 1'b1;
                    emit_err  = 1'b1;
                end
                else if (!top_is_lparen)
                begin
                    want_emit = 1'b1;
                    emit_sym  = top_reg;
                    do_pop    = 1'b1;
                    done      = 1'b0;
                end
                else
                begin
                    do_pop = 1'b1; // matching '(' is dropped
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bi2p_pkg::ST_IDLE:
            begin
                if (in_valid && (bi2p_pkg::kind_of(ch) != bi2p_pkg::KIND_SKIP))
                begin
                    state_next = bi2p_pkg::ST_LOAD;
                end
            end
            bi2p_pkg::ST_LOAD:
            begin
                state_next = bi2p_pkg::ST_TEST;
            end
            bi2p_pkg::ST_TEST:
            begin
                if (go)
                begin
                    state_next = done ? bi2p_pkg::ST_IDLE : bi2p_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = bi2p_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        ch_next        = ch_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        paren_next     = paren_reg;
        out_valid_next = out_valid_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        in_ready       = (state_reg == bi2p_pkg::ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_ready && in_valid)
        begin
            ch_next   = ch;
            kind_next = bi2p_pkg::kind_of(ch);
        end

        if (go)
        begin
            if (want_emit)
            begin
                out_valid_next = 1'b1;
                sym_next       = emit_sym;
                last_next      = emit_last;
                error_next     = emit_err;
            end
            if (do_pop)
            begin
                count_next = count_dec;
                if (top_is_lparen)
                begin
                    paren_next = paren_reg - CW'(1);
                end
            end
            if (do_push)
            begin
                count_next = count_reg + CW'(1);
                if (kind_reg == bi2p_pkg::KIND_LPAREN)
                begin
                    paren_next = paren_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bi2p_pkg::ST_IDLE;
            count_reg     <= '0;
            paren_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            paren_reg     <= paren_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        kind_reg  <= kind_next;
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        error_reg <= error_next;
    end

    assign out_valid = out_valid_reg;
    assign sym       = sym_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

// ===== rtl/bi2p_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Uses boolean_infix_to_postfix_core_macros.svh and bi2p_pkg.
`include "boolean_infix_to_postfix_core_macros.svh"

module bi2p_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] ch,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] sym,
    input logic       last,
    input logic       error
);

    // Reset seen at one edge leaves no beat at the next
    `BI2P_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_n |=> !out_valid, "output beat during reset")

    `BI2P_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(sym) && $stable(last) && $stable(error), "stalled output beat changed")

    `BI2P_ASSERT(a_err_clean, out_valid && error |-> (sym == 8'h00) && !last, "error beat carries data")

    `BI2P_ASSERT(a_last_clean, out_valid && last |-> (sym == bi2p_pkg::CH_END) && !error, "terminator beat not zero")

    `BI2P_ASSERT(a_end_busy, in_valid && in_ready && (ch == bi2p_pkg::CH_END) |=> !in_ready, "end of expression not processed")

endmodule

bind boolean_infix_to_postfix_core bi2p_checker u_bi2p_checker (.*);
